// ===== rtl/core/rope_pkg.sv =====
// Package for the rotary position rotation block: constants, types and build-time tables.
package rope_pkg;

  localparam int unsigned HEAD_DIM      = 128;
  localparam int unsigned ROM_DEPTH     = 64;
  localparam int unsigned IDX_W         = 6;
  localparam int unsigned DATA_W        = 16;
  localparam int unsigned TAYLOR_TERMS  = 17;
  localparam int unsigned S_TDATA_W     = 88;
  localparam int unsigned M_TDATA_W     = 72;

  localparam logic [63:0] LN10K_Q32  = 64'd39558110683;
  localparam logic [63:0] LN2_Q32    = 64'd2977044472;
  localparam logic [63:0] INV2PI_Q32 = 64'd683565276;
  localparam logic [31:0] TWOPI_Q29  = 32'd3373259426;

  // Pipeline stage indexes
  localparam int unsigned ST_ROM  = 0;
  localparam int unsigned ST_PH   = 1;
  localparam int unsigned ST_ANG  = 2;
  localparam int unsigned ST_TAY  = 3;
  localparam int unsigned ST_QUAD = ST_TAY + 2 * TAYLOR_TERMS;
  localparam int unsigned ST_MUL  = ST_QUAD + 1;
  localparam int unsigned ST_OUT  = ST_MUL + 1;
  localparam int unsigned NSTAGE  = ST_OUT + 1;

  typedef logic [31:0] freq_rom_t [ROM_DEPTH];
  typedef logic [32:0] recip_t [TAYLOR_TERMS + 1];

  typedef struct {
    logic        [15:0] pos;
    logic [IDX_W-1:0]   idx;
    logic signed [15:0] qe;
    logic signed [15:0] qo;
    logic signed [15:0] ke;
    logic signed [15:0] ko;
    logic        [31:0] entry;
    logic        [1:0]  quad;
    logic        [29:0] f;
    logic        [30:0] a;
    logic        [31:0] t;
    logic        [31:0] p;
    logic signed [33:0] sv;
    logic signed [33:0] cv;
    logic signed [49:0] prod [8];
    logic        [15:0] res  [4];
  } pipe_t;

  // Frequency per pair in turns, Q0.32: exp by truncated series, then scale by 1/(2 pi)
  function automatic freq_rom_t build_freq_rom();
    freq_rom_t          tbl;
    logic        [63:0] x;
    logic        [63:0] r;
    logic        [63:0] t;
    logic        [63:0] ev;
    logic        [63:0] q;
    logic signed [65:0] e;
    int                 n;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      x = (64'(2 * i) * LN10K_Q32) / HEAD_DIM;
      n = int'(x / LN2_Q32);
      r = x - 64'(n) * LN2_Q32;
      if (n >= 32) begin
        tbl[i] = '0;
      end else begin
        t = 64'd1 << 32;
        e = 66'sd4294967296;
        for (int k = 1; k <= 16; k++) begin
          t = ((t * r) >> 32) / 64'(k);
          if (k % 2 == 1) e = e - $signed({2'b00, t});
          else            e = e + $signed({2'b00, t});
        end
        if (e < 0) e = '0;
        ev = e[63:0];
        q = (ev * INV2PI_Q32 + (64'd1 << (31 + n))) >> (32 + n);
        tbl[i] = q[31:0];
      end
    end
    return tbl;
  endfunction

  // Reciprocals for exact floor division of a 32-bit value by each series index
  function automatic recip_t build_recip();
    recip_t      tbl;
    logic [65:0] v;
    int          l;
    tbl[0] = '0;
    for (int k = 1; k <= TAYLOR_TERMS; k++) begin
      l = $clog2(k);
      v = ((66'd1 << (32 + l)) + 66'(k) - 66'd1) / 66'(k);
      tbl[k] = v[32:0];
    end
    return tbl;
  endfunction

  localparam freq_rom_t FREQ_ROM = build_freq_rom();
  localparam recip_t    RECIP_M  = build_recip();

  // Round a Q30-scaled sum to Q12, half up, and saturate to 16 bits
  function automatic logic [15:0] round_sat(input logic signed [50:0] v);
    logic signed [50:0] r;
    r = (v + 51'sd536870912) >>> 30;
    if (r > 51'sd32767) return 16'h7fff;
    else if (r < -51'sd32768) return 16'h8000;
    else return r[15:0];
  endfunction

endpackage

// ===== rtl/core/rotary_position_rotation.sv =====
// Rotary position rotation: one query/key element pair rotated per word, deep pipeline.
// Takes one word per cycle and returns one word per cycle whenever the output is not stalled.
// The pipeline length is set by the sine/cosine series, summed to 17 terms,
// each one stage for the angle multiply and one for the exact reciprocal divide, after a
// frequency lookup, the phase and angle multiplies, and ahead of quadrant mapping, the
// eight rotation products and the rounding stage. Each stage holds its word while the next
// cannot take it, so a stalled output does not block intake until the pipeline has filled.
module rotary_position_rotation
  import rope_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // position, pair_index, q_even, q_odd, k_even, k_odd, zero pad
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // q_even_out, q_odd_out, k_even_out, k_odd_out, pair_index_out, zero pad
  output logic [M_TDATA_W-1:0] m_axis_tdata_o
);

  pipe_t             in_w;
  pipe_t             pipe_d [NSTAGE];
  pipe_t             pipe_q [NSTAGE];
  logic [NSTAGE-1:0] valid_q;
  logic [NSTAGE:0]   rdy;

  always_comb begin
    in_w     = pipe_q[ST_OUT];
    in_w.pos = s_axis_tdata_i[15:0];
    in_w.idx = s_axis_tdata_i[21:16];
    in_w.qe  = $signed(s_axis_tdata_i[37:22]);
    in_w.qo  = $signed(s_axis_tdata_i[53:38]);
    in_w.ke  = $signed(s_axis_tdata_i[69:54]);
    in_w.ko  = $signed(s_axis_tdata_i[85:70]);
  end

  assign rdy[NSTAGE] = m_axis_tready_i;

  for (genvar j = 0; j < NSTAGE; j++) begin : g_stage
    assign rdy[j] = !valid_q[j] || rdy[j+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j] <= 1'b0;
      end else if (rdy[j]) begin
        if (j == 0) valid_q[j] <= s_axis_tvalid_i;
        else        valid_q[j] <= valid_q[(j == 0) ? 0 : j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[j]) begin
        pipe_q[j] <= pipe_d[j];
      end
    end

    if (j == ST_ROM) begin : g_rom
      always_comb begin
        pipe_d[j]       = in_w;
        pipe_d[j].entry = FREQ_ROM[in_w.idx];
      end
    end else if (j == ST_PH) begin : g_phase
      logic [47:0] ph;
      always_comb begin
        ph             = 48'(pipe_q[j-1].pos) * 48'(pipe_q[j-1].entry);
        pipe_d[j]      = pipe_q[j-1];
        pipe_d[j].quad = ph[31:30];
        pipe_d[j].f    = ph[29:0];
      end
    end else if (j == ST_ANG) begin : g_angle
      logic [61:0] ang;
      always_comb begin
        ang          = 62'(pipe_q[j-1].f) * 62'(TWOPI_Q29);
        pipe_d[j]    = pipe_q[j-1];
        pipe_d[j].a  = ang[61:31];
        pipe_d[j].t  = 32'd1073741824;
        pipe_d[j].sv = '0;
        pipe_d[j].cv = 34'sd1073741824;
      end
    end else if (j < ST_QUAD) begin : g_series
      localparam int K = (j - ST_TAY) / 2 + 1;
      if ((j - ST_TAY) % 2 == 0) begin : g_mul
        logic [62:0] ta;
        always_comb begin
          ta          = 63'(pipe_q[j-1].t) * 63'(pipe_q[j-1].a);
          pipe_d[j]   = pipe_q[j-1];
          pipe_d[j].p = ta[61:30];
        end
      end else begin : g_div
        localparam logic [32:0] M  = RECIP_M[K];
        localparam int          SH = 32 + $clog2(K);
        logic        [64:0] pm;
        logic        [31:0] tn;
        logic signed [33:0] term;
        always_comb begin
          pm        = 65'(pipe_q[j-1].p) * 65'(M);
          tn        = 32'(pm >> SH);
          term      = $signed({2'b00, tn});
          pipe_d[j]   = pipe_q[j-1];
          pipe_d[j].t = tn;
          if (K % 2 == 1) begin
            if (K % 4 == 1) pipe_d[j].sv = pipe_q[j-1].sv + term;
            else            pipe_d[j].sv = pipe_q[j-1].sv - term;
          end else begin
            if (K % 4 == 2) pipe_d[j].cv = pipe_q[j-1].cv - term;
            else            pipe_d[j].cv = pipe_q[j-1].cv + term;
          end
        end
      end
    end else if (j == ST_QUAD) begin : g_quad
      always_comb begin
        pipe_d[j] = pipe_q[j-1];
        case (pipe_q[j-1].quad)
          2'd0: begin
            pipe_d[j].sv = pipe_q[j-1].sv;
            pipe_d[j].cv = pipe_q[j-1].cv;
          end
          2'd1: begin
            pipe_d[j].sv = pipe_q[j-1].cv;
            pipe_d[j].cv = -pipe_q[j-1].sv;
          end
          2'd2: begin
            pipe_d[j].sv = -pipe_q[j-1].sv;
            pipe_d[j].cv = -pipe_q[j-1].cv;
          end
          default: begin
            pipe_d[j].sv = -pipe_q[j-1].cv;
            pipe_d[j].cv = pipe_q[j-1].sv;
          end
        endcase
      end
    end else if (j == ST_MUL) begin : g_prod
      always_comb begin
        pipe_d[j]         = pipe_q[j-1];
        pipe_d[j].prod[0] = 50'(pipe_q[j-1].qe) * 50'(pipe_q[j-1].cv);
        pipe_d[j].prod[1] = 50'(pipe_q[j-1].qo) * 50'(pipe_q[j-1].sv);
        pipe_d[j].prod[2] = 50'(pipe_q[j-1].qe) * 50'(pipe_q[j-1].sv);
        pipe_d[j].prod[3] = 50'(pipe_q[j-1].qo) * 50'(pipe_q[j-1].cv);
        pipe_d[j].prod[4] = 50'(pipe_q[j-1].ke) * 50'(pipe_q[j-1].cv);
        pipe_d[j].prod[5] = 50'(pipe_q[j-1].ko) * 50'(pipe_q[j-1].sv);
        pipe_d[j].prod[6] = 50'(pipe_q[j-1].ke) * 50'(pipe_q[j-1].sv);
        pipe_d[j].prod[7] = 50'(pipe_q[j-1].ko) * 50'(pipe_q[j-1].cv);
      end
    end else begin : g_round
      always_comb begin
        pipe_d[j]        = pipe_q[j-1];
        pipe_d[j].res[0] = round_sat(51'(pipe_q[j-1].prod[0]) - 51'(pipe_q[j-1].prod[1]));
        pipe_d[j].res[1] = round_sat(51'(pipe_q[j-1].prod[2]) + 51'(pipe_q[j-1].prod[3]));
        pipe_d[j].res[2] = round_sat(51'(pipe_q[j-1].prod[4]) - 51'(pipe_q[j-1].prod[5]));
        pipe_d[j].res[3] = round_sat(51'(pipe_q[j-1].prod[6]) + 51'(pipe_q[j-1].prod[7]));
      end
    end
  end

  assign s_axis_tready_o = rdy[0];
  assign m_axis_tvalid_o = valid_q[ST_OUT];
  assign m_axis_tdata_o  = {2'b00, pipe_q[ST_OUT].idx, pipe_q[ST_OUT].res[3],
                            pipe_q[ST_OUT].res[2], pipe_q[ST_OUT].res[1],
                            pipe_q[ST_OUT].res[0]};

endmodule

// ===== rtl/core/rope_checker.sv =====
// Port-level checks for the rotary position rotation block, bound to the top level.
module rope_checker
  import rope_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tready_o,
  input logic                 m_axis_tvalid_o,
  input logic                 m_axis_tready_i,
  input logic [M_TDATA_W-1:0] m_axis_tdata_o
);

  // hold a stalled output word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled output word changed");

  // a draining output means every stage can advance
  a_ready_flow: assert property (@(posedge clk_i) m_axis_tready_i |-> s_axis_tready_o)
    else $error("input stalled while output drains");

  a_reset_empty: assert property (@(posedge clk_i) $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("output word present straight after reset");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[M_TDATA_W-1:70] == 2'b00)
    else $error("output pad bits not zero");

endmodule

bind rotary_position_rotation rope_checker u_rope_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// ===== sim/rope_checker.sv =====
// Checker for the rotary position rotation block: predicts each rotated word and compares.
`timescale 1ns / 1ps
module rope_scoreboard
  import rope_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  input  logic [S_TDATA_W-1:0] s_tdata_i,
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  input  logic [M_TDATA_W-1:0] m_tdata_i,
  output int                   pending_o,
  output int                   errors_o
);

  typedef struct packed {
    logic [5:0]  idx;
    logic [15:0] ko;
    logic [15:0] ke;
    logic [15:0] qo;
    logic [15:0] qe;
  } rotated_t;

  logic [31:0] freq_turns [ROM_DEPTH];
  rotated_t    rotated_q [$];

  // Frequency in turns, Q0.32: e^-r by truncated series, scaled by 1/(2 pi) and 2^-n
  function automatic logic [31:0] freq_of(int unsigned i);
    longint unsigned x, n, r, t;
    longint e;
    x = (64'(2 * i) * 64'd39558110683) / HEAD_DIM;
    n = x / 64'd2977044472;
    r = x - n * 64'd2977044472;
    if (n >= 32) return '0;
    t = 64'd1 << 32;
    e = 64'sd4294967296;
    for (int k = 1; k <= 16; k++) begin
      t = ((t * r) >> 32) / longint'(k);
      if (k % 2 == 1) e = e - longint'(t);
      else e = e + longint'(t);
    end
    if (e < 0) e = 0;
    t = (longint'(e) * 64'd683565276 + (64'd1 << (31 + n))) >> (32 + n);
    return t[31:0];
  endfunction

  function automatic logic [15:0] q30_to_q12(longint v);
    longint r;
    r = (v + 64'sd536870912) >>> 30;
    if (r > 32767) return 16'h7fff;
    if (r < -32768) return 16'h8000;
    return r[15:0];
  endfunction

  function automatic rotated_t rotate_pair(logic [S_TDATA_W-1:0] w);
    logic [15:0]     pos;
    logic [5:0]      idx;
    longint          qe, qo, ke, ko, s0, c0, s, c;
    longint unsigned ph, f, a, t;
    rotated_t        res;
    pos = w[15:0];
    idx = w[21:16];
    qe  = longint'($signed(w[37:22]));
    qo  = longint'($signed(w[53:38]));
    ke  = longint'($signed(w[69:54]));
    ko  = longint'($signed(w[85:70]));
    ph  = (64'(pos) * 64'(freq_turns[idx])) & 64'hffff_ffff;
    f   = ph & 64'h3fff_ffff;
    a   = ((f * 64'd3373259426) >> 29) >> 2;
    // Taylor series to order 17, terms truncated in Q30
    t  = 64'd1 << 30;
    s0 = 0;
    c0 = 64'sd1073741824;
    for (int k = 1; k <= 17; k++) begin
      t = ((t * a) >> 30) / longint'(k);
      case (k % 4)
        1: s0 = s0 + longint'(t);
        2: c0 = c0 - longint'(t);
        3: s0 = s0 - longint'(t);
        default: c0 = c0 + longint'(t);
      endcase
    end
    case (ph[31:30])
      2'd0: begin s = s0;  c = c0;  end
      2'd1: begin s = c0;  c = -s0; end
      2'd2: begin s = -s0; c = -c0; end
      default: begin s = -c0; c = s0; end
    endcase
    res.qe  = q30_to_q12(qe * c - qo * s);
    res.qo  = q30_to_q12(qe * s + qo * c);
    res.ke  = q30_to_q12(ke * c - ko * s);
    res.ko  = q30_to_q12(ke * s + ko * c);
    res.idx = idx;
    return res;
  endfunction

  initial begin
    for (int i = 0; i < ROM_DEPTH; i++) freq_turns[i] = freq_of(i);
  end

  always @(posedge clk_i or negedge rst_ni) begin
    rotated_t want, got;
    if (!rst_ni) begin
      rotated_q.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (s_tvalid_i && s_tready_i) rotated_q.push_back(rotate_pair(s_tdata_i));
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i[69:0];
        if (rotated_q.size() == 0) begin
          if (errors_o < 10) $display("unexpected word %h", got);
          errors_o <= errors_o + 1;
        end else begin
          want = rotated_q.pop_front();
          if (got != want || m_tdata_i[71:70] != 2'b00) begin
            if (errors_o < 10)
              $display("mismatch idx %0d/%0d qe %h/%h qo %h/%h ke %h/%h ko %h/%h (exp/act)",
                       want.idx, got.idx, want.qe, got.qe, want.qo, got.qo,
                       want.ke, got.ke, want.ko, got.ko);
            errors_o <= errors_o + 1;
          end
        end
      end
      pending_o <= rotated_q.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the rotary position rotation block: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module tb;
  import rope_pkg::*;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_axis_tdata_i;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;
  int                   pending;
  int                   errors;
  int                   cycles = 0;
  int                   ready_hold = 0;

  rotary_position_rotation u_top (.*);

  rope_scoreboard u_chk (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid_i), .s_tready_i(s_axis_tready_o), .s_tdata_i(s_axis_tdata_i),
    .m_tvalid_i(m_axis_tvalid_o), .m_tready_i(m_axis_tready_i), .m_tdata_i(m_axis_tdata_o),
    .pending_o(pending), .errors_o(errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Random back-pressure: mostly short runs, now and then a long stall or a free stretch
  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 2) != 0);
      ready_hold      <= pick_gap() * (($urandom_range(0, 9) == 0) ? 3 : 1);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [15:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_word(input logic [15:0] pos, input logic [5:0] idx,
                           input logic [15:0] qe, input logic [15:0] qo,
                           input logic [15:0] ke, input logic [15:0] ko);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {2'b00, ko, ke, qo, qe, idx, pos};
    do @(negedge clk_i); while (!s_axis_tready_o);
    @(posedge clk_i);
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extremes of position and pair index, full-scale data for saturation, tiny frequencies
    send_word(16'd0,     6'd0,  16'h1000, 16'h0000, 16'h0000, 16'h1000);
    send_word(16'd1,     6'd0,  16'h1000, 16'h0000, 16'h0000, 16'h1000);
    send_word(16'd65535, 6'd0,  16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
    send_word(16'd65535, 6'd63, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_word(16'd0,     6'd63, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    send_word(16'd1,     6'd63, 16'hffff, 16'h0001, 16'h0001, 16'hffff);
    send_word(16'd12345, 6'd32, 16'h4000, 16'hc000, 16'h1234, 16'hedcb);
    send_word(16'd40000, 6'd40, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
    send_word(16'd65535, 6'd50, 16'h8000, 16'h7fff, 16'h8000, 16'h8000);
    send_word(16'd1,     6'd1,  16'h8000, 16'h8000, 16'h8000, 16'h8000);
    for (int i = 0; i < 8; i++)
      send_word(16'(i * 3 + 1), 6'(i * 9), 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);

    for (int n = 0; n < 400; n++) begin
      logic [15:0] pos;
      logic [5:0]  idx;
      pos = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 64)) : 16'($urandom());
      idx = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(55, 63)) : 6'($urandom());
      send_word(pos, idx, rand_elem(), rand_elem(), rand_elem(), rand_elem());
      // Drain everything once midway
      if (n == 200) begin
        s_axis_tvalid_i <= 1'b0;
        do @(negedge clk_i); while (pending != 0);
        @(posedge clk_i);
      end
    end
    s_axis_tvalid_i <= 1'b0;

    do @(negedge clk_i); while (pending != 0);
    repeat (60) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
